/* hdl/salc_pkg.sv */
// Package for the set-associative LRU byte cache.
// Holds the controller state type, access codes and default geometry.
// No dependencies.
package salc_pkg;

    // Default geometry handed to the top level
    localparam int DEF_ADDR_BITS  = 16;
    localparam int DEF_LINE_BYTES = 16;
    localparam int DEF_LINES      = 64;
    localparam int DEF_WAYS       = 4;

    // Fixed port widths
    localparam int ADDR_PORT_W = 16;
    localparam int BYTE_W      = 8;
    localparam int VLA_W       = 12;

    // Access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Controller states
    typedef enum logic [2:0]
    {
        ST_CLEAR,
        ST_IDLE,
        ST_META,
        ST_WBACK,
        ST_FILL,
        ST_SERVE,
        ST_WTHRU,
        ST_DONE
    } salc_state_t;

endpackage

/* hdl/salc_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module salc_ram #(
    parameter int          WIDTH = 8,
    parameter longint      DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/set_assoc_lru_cache_core.sv */
// Set-associative LRU byte cache with built-in backing memory: top level.
// Depends on salc_pkg and salc_ram.
//
// Usage
//   Command channel: an access (command, address, write_data) is taken at a
//   rising edge with start high and busy low. busy stays high until the
//   access has finished. Each access gives exactly one result word, shown for
//   one cycle with done high: hit, read_data (0 on writes), wrote_back and
//   victim_line_address (0 unless a dirty line went back to memory).
//   The receiver cannot stall; a result is gone after its done cycle.
//   cfg_write_en/cfg_write_data write write_back_mode (reset 1); the user must
//   write it only while idle, as the block itself does not enforce this.
// Sequence per access: a hit passes META, SERVE and DONE; a miss adds a
//   line fill (FILL) before SERVE, preceded by a write-back (WBACK) when a
//   dirty victim goes back; a write in write-through mode adds a line store
//   (WTHRU). Line store and backing memory have byte-wide ports, so lines move byte by byte.
//   One access at a time: the next one is taken in the cycle after done.
// Reset: valid bits and mode reset at once; the backing memory is then
//   zeroed one byte per cycle with busy high.
module set_assoc_lru_cache_core import salc_pkg::*; #(
    parameter int ADDR_BITS  = DEF_ADDR_BITS,
    parameter int LINE_BYTES = DEF_LINE_BYTES,
    parameter int LINES      = DEF_LINES,
    parameter int WAYS       = DEF_WAYS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic                   cfg_write_data,
    input  logic                   start,
    output logic                   busy,
    input  logic                   command,
    input  logic [ADDR_PORT_W-1:0] address,
    input  logic [BYTE_W-1:0]      write_data,
    output logic                   done,
    output logic                   hit,
    output logic [BYTE_W-1:0]      read_data,
    output logic                   wrote_back,
    output logic [VLA_W-1:0]       victim_line_address
);

    // Geometry
    localparam int NWAYS  = (LINES >= WAYS) ? WAYS : LINES;
    localparam int NSETSF = (LINES >= WAYS) ? LINES / WAYS : 1;
    localparam int OBITS  = $clog2(LINE_BYTES + 1) - 1;
    localparam int IBITS  = $clog2(NSETSF + 1) - 1;
    localparam int NSETS  = 1 << IBITS;
    localparam int SETW   = (IBITS > 0) ? IBITS : 1;
    localparam int TAGW   = (ADDR_BITS > OBITS + IBITS) ? ADDR_BITS - OBITS - IBITS : 1;
    localparam int WAYW   = (NWAYS > 1) ? $clog2(NWAYS) : 1;
    localparam int RANKW  = WAYW;
    localparam int LINEW  = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int DDEPTH = LINES * LINE_BYTES;
    localparam int DAW    = (DDEPTH > 1) ? $clog2(DDEPTH) : 1;
    localparam int CNTW   = $clog2(LINE_BYTES + 1);
    localparam int MW     = TAGW + 1 + RANKW;
    localparam int ROWW   = NWAYS * MW;
    localparam longint MDEPTH = longint'(1) << ADDR_BITS;
    localparam logic [ADDR_BITS-1:0] OMASK = ADDR_BITS'((longint'(1) << OBITS) - 1);
    localparam logic [ADDR_BITS-1:0] SMASK = ADDR_BITS'((longint'(1) << IBITS) - 1);

    // Control and datapath registers
    salc_state_t          state_reg, state_next;
    logic                 wbm_reg, wbm_next;
    logic                 cmd_reg, cmd_next;
    logic [ADDR_BITS-1:0] addr_reg, addr_next;
    logic [BYTE_W-1:0]    wdata_reg, wdata_next;
    logic                 hit_reg, hit_next;
    logic                 wb_reg, wb_next;
    logic [LINEW-1:0]     line_reg, line_next;
    logic [ADDR_BITS-1:0] ev_reg, ev_next;
    logic [VLA_W-1:0]     vla_reg, vla_next;
    logic [CNTW-1:0]      cnt_reg, cnt_next;
    logic [ADDR_BITS-1:0] clr_reg, clr_next;
    logic [NWAYS-1:0]     valid_reg [NSETS];
    logic [NWAYS-1:0]     valid_next [NSETS];

    // Decoded access fields
    logic [ADDR_BITS-1:0] addr_in;
    logic [SETW-1:0]      set_in;
    logic [SETW-1:0]      set_q;
    logic [TAGW-1:0]      tag_q;
    logic [ADDR_BITS-1:0] offset_q;
    logic [ADDR_BITS-1:0] line_base_q;
    logic                 accept;
    logic                 loop_last;

    // Tag store view of the addressed set
    logic [ROWW-1:0]      row_rd;
    logic [ROWW-1:0]      row_new;
    logic [TAGW-1:0]      tag_w   [NWAYS];
    logic                 dirty_w [NWAYS];
    logic [RANKW-1:0]     rank_w  [NWAYS];
    logic [NWAYS-1:0]     vrow;
    logic                 hit_c;
    logic                 found;
    logic [WAYW-1:0]      hsel;
    logic [WAYW-1:0]      vic;
    logic [WAYW-1:0]      sel;
    logic                 sel_valid;
    logic [RANKW-1:0]     sel_rank;
    logic [TAGW-1:0]      sel_tag;
    logic                 sel_dirty;
    logic                 new_dirty;
    logic [RANKW-1:0]     rank_n;
    logic                 needs_wb;
    logic [ADDR_BITS-1:0] ev_c;
    logic [VLA_W-1:0]     vla_c;
    logic [LINEW-1:0]     line_c;

    // Memory ports
    logic                 dram_we;
    logic [DAW-1:0]       dram_waddr, dram_raddr;
    logic [BYTE_W-1:0]    dram_wdata, dram_rdata;
    logic                 mem_we;
    logic [ADDR_BITS-1:0] mem_waddr, mem_raddr;
    logic [BYTE_W-1:0]    mem_wdata, mem_rdata;

    assign accept      = start && !busy;
    assign addr_in     = ADDR_BITS'(address);
    assign set_in      = SETW'((addr_in >> OBITS) & SMASK);
    assign set_q       = SETW'((addr_reg >> OBITS) & SMASK);
    assign tag_q       = TAGW'(addr_reg >> (OBITS + IBITS));
    assign offset_q    = addr_reg & OMASK;
    assign line_base_q = addr_reg & ~OMASK;
    assign loop_last   = (cnt_reg == CNTW'(LINE_BYTES));
    assign vrow        = valid_reg[set_q];

    // Unpack the set row
    always_comb
    begin
        for (int i = 0; i < NWAYS; i++)
        begin
            tag_w[i]   = row_rd[i*MW + RANKW + 1 +: TAGW];
            dirty_w[i] = row_rd[i*MW + RANKW];
            rank_w[i]  = row_rd[i*MW +: RANKW];
        end
    end

    // Hit search and victim choice: first invalid way, else the oldest
    always_comb
    begin
        hit_c = 1'b0;
        hsel  = '0;
        found = 1'b0;
        vic   = '0;
        for (int i = 0; i < NWAYS; i++)
        begin
            if (!hit_c && vrow[i] && tag_w[i] == tag_q)
            begin
                hit_c = 1'b1;
                hsel  = WAYW'(i);
            end
        end
        for (int i = 0; i < NWAYS; i++)
        begin
            if (!found && !vrow[i])
            begin
                found = 1'b1;
                vic   = WAYW'(i);
            end
        end
        if (!found)
        begin
            for (int i = 0; i < NWAYS; i++)
            begin
                if (rank_w[i] == RANKW'(NWAYS - 1))
                begin
                    vic = WAYW'(i);
                end
            end
        end
    end

    assign sel       = hit_c ? hsel : vic;
    assign sel_valid = vrow[sel];
    assign sel_rank  = rank_w[sel];
    assign sel_tag   = tag_w[sel];
    assign sel_dirty = dirty_w[sel];
    assign needs_wb  = !hit_c && sel_valid && sel_dirty && wbm_reg;
    assign new_dirty = (hit_c && sel_dirty) || (cmd_reg == CMD_WRITE && wbm_reg);
    assign ev_c      = (ADDR_BITS'(sel_tag) << (OBITS + IBITS)) |
                       (ADDR_BITS'(set_q) << OBITS);
    assign vla_c     = VLA_W'((ADDR_BITS'(sel_tag) << IBITS) | ADDR_BITS'(set_q));
    assign line_c    = LINEW'(int'(set_q) * NWAYS + int'(sel));

    // New set row: recency update and the touched way's tag and dirty bit
    always_comb
    begin
        row_new = row_rd;
        rank_n  = '0;
        for (int i = 0; i < NWAYS; i++)
        begin
            rank_n = rank_w[i];
            if (WAYW'(i) == sel)
            begin
                rank_n = '0;
            end
            else if (vrow[i] && (!sel_valid || rank_w[i] < sel_rank))
            begin
                rank_n = rank_w[i] + 1'b1;
            end
            row_new[i*MW +: RANKW] = rank_n;
            if (WAYW'(i) == sel)
            begin
                row_new[i*MW + RANKW]              = new_dirty;
                row_new[i*MW + RANKW + 1 +: TAGW]  = tag_q;
            end
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_META;
                end
            end
            ST_META:
            begin
                if (hit_c)
                begin
                    state_next = ST_SERVE;
                end
                else if (needs_wb)
                begin
                    state_next = ST_WBACK;
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_WBACK:
            begin
                if (loop_last)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (loop_last)
                begin
                    state_next = ST_SERVE;
                end
            end
            ST_SERVE:
            begin
                if (cmd_reg == CMD_WRITE && !wbm_reg)
                begin
                    state_next = ST_WTHRU;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_WTHRU:
            begin
                if (loop_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        wbm_next   = cfg_write_en ? cfg_write_data : wbm_reg;
        cmd_next   = accept ? command : cmd_reg;
        addr_next  = accept ? addr_in : addr_reg;
        wdata_next = accept ? write_data : wdata_reg;
        hit_next   = hit_reg;
        wb_next    = wb_reg;
        line_next  = line_reg;
        ev_next    = ev_reg;
        vla_next   = vla_reg;
        clr_next   = (state_reg == ST_CLEAR) ? clr_reg + 1'b1 : clr_reg;
        valid_next = valid_reg;
        if (state_reg == ST_META)
        begin
            hit_next  = hit_c;
            wb_next   = needs_wb;
            line_next = line_c;
            ev_next   = ev_c;
            vla_next  = needs_wb ? vla_c : '0;
            valid_next[set_q][sel] = 1'b1;
        end
        if ((state_reg == ST_WBACK || state_reg == ST_FILL || state_reg == ST_WTHRU)
            && !loop_last)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else
        begin
            cnt_next = '0;
        end
    end

    // Line store ports
    always_comb
    begin
        dram_raddr = DAW'(int'(line_reg) * LINE_BYTES + int'(cnt_reg));
        dram_waddr = DAW'(int'(line_reg) * LINE_BYTES + int'(cnt_reg) - 1);
        dram_wdata = mem_rdata;
        dram_we    = (state_reg == ST_FILL) && (cnt_reg != '0);
        if (state_reg == ST_SERVE)
        begin
            dram_raddr = DAW'(int'(line_reg) * LINE_BYTES + int'(offset_q));
            dram_waddr = DAW'(int'(line_reg) * LINE_BYTES + int'(offset_q));
            dram_wdata = wdata_reg;
            dram_we    = (cmd_reg == CMD_WRITE);
        end
    end

    // Backing memory ports
    always_comb
    begin
        mem_raddr = line_base_q + ADDR_BITS'(cnt_reg);
        mem_wdata = dram_rdata;
        mem_we    = 1'b0;
        mem_waddr = line_base_q + ADDR_BITS'(cnt_reg - 1'b1);
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            ST_WBACK:
            begin
                mem_we    = (cnt_reg != '0);
                mem_waddr = ev_reg + ADDR_BITS'(cnt_reg - 1'b1);
            end
            ST_WTHRU:
            begin
                mem_we = (cnt_reg != '0);
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            wbm_reg   <= 1'b1;
            cnt_reg   <= '0;
            clr_reg   <= '0;
            hit_reg   <= 1'b0;
            wb_reg    <= 1'b0;
            vla_reg   <= '0;
            for (int s = 0; s < NSETS; s++)
            begin
                valid_reg[s] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            wbm_reg   <= wbm_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
            hit_reg   <= hit_next;
            wb_reg    <= wb_next;
            vla_reg   <= vla_next;
            valid_reg <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        addr_reg  <= addr_next;
        wdata_reg <= wdata_next;
        line_reg  <= line_next;
        ev_reg    <= ev_next;
    end

    // Tag, dirty and recency store: one row per set
    salc_ram #(
        .WIDTH (ROWW),
        .DEPTH (NSETS)
    ) u_meta_ram (
        .clk   (clk),
        .we    (state_reg == ST_META),
        .waddr (set_q),
        .wdata (row_new),
        .raddr (set_in),
        .rdata (row_rd)
    );

    // Cached line bytes
    salc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DDEPTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (dram_we),
        .waddr (dram_waddr),
        .wdata (dram_wdata),
        .raddr (dram_raddr),
        .rdata (dram_rdata)
    );

    // Backing memory
    salc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (MDEPTH)
    ) u_back_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Result word
    assign busy                = (state_reg != ST_IDLE);
    assign done                = (state_reg == ST_DONE);
    assign hit                 = hit_reg;
    assign read_data           = (cmd_reg == CMD_WRITE) ? '0 : dram_rdata;
    assign wrote_back          = wb_reg;
    assign victim_line_address = vla_reg;

`ifndef SYNTHESIS
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_wb_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        done && wrote_back |-> !hit && wbm_reg)
        else $error("write-back reported on a hit or in write-through mode");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy && !done)
        else $error("accepted word did not raise busy");

    a_vla_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !wrote_back |-> victim_line_address == '0)
        else $error("victim address set without write-back");
`endif

endmodule

/* bench/cache_checker.sv */
// Checker for the set-associative LRU byte cache: watches the command and
// result channels, predicts every result word and compares field by field.
// Depends on salc_pkg.
module cache_checker import salc_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write_en,
    input  logic                   cfg_write_data,
    input  logic                   start,
    input  logic                   busy,
    input  logic                   command,
    input  logic [ADDR_PORT_W-1:0] address,
    input  logic [BYTE_W-1:0]      write_data,
    input  logic                   done,
    input  logic                   hit,
    input  logic [BYTE_W-1:0]      read_data,
    input  logic                   wrote_back,
    input  logic [VLA_W-1:0]       victim_line_address,
    output int                     errors,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NWAYS = DEF_WAYS;
    localparam int NSETS = DEF_LINES / DEF_WAYS;
    localparam int NLB   = DEF_LINE_BYTES;

    typedef struct packed {
        logic              hit;
        logic [BYTE_W-1:0] rdata;
        logic              wb;
        logic [VLA_W-1:0]  vla;
    } cache_result_t;

    // Shadow cache and memory
    logic              wb_mode;
    logic              sh_valid [DEF_LINES];
    logic              sh_dirty [DEF_LINES];
    logic [7:0]        sh_tag   [DEF_LINES];
    logic [1:0]        sh_rank  [DEF_LINES];
    logic [7:0]        sh_bytes [DEF_LINES][NLB];
    logic [7:0]        sh_mem   [65536];
    cache_result_t     expected_words[$];

    // Make way w of the set at base the most recent
    function automatic void promote(int base, int w);
        logic       was;
        logic [1:0] old;
        was = sh_valid[base + w];
        old = sh_rank[base + w];
        for (int i = 0; i < NWAYS; i++)
            if (i != w && sh_valid[base + i] && (!was || sh_rank[base + i] < old))
                sh_rank[base + i]++;
        sh_rank[base + w] = 0;
    endfunction

    function automatic cache_result_t access_cache(logic wr, logic [15:0] a, logic [7:0] d);
        cache_result_t r;
        logic [3:0]  off;
        logic [3:0]  set;
        logic [7:0]  tg;
        logic [15:0] lb;
        logic [15:0] ev;
        logic [1:0]  oldest;
        int base;
        int v;
        logic found;
        r = '0;
        off = a[3:0];
        set = a[7:4];
        tg = a[15:8];
        lb = {a[15:4], 4'h0};
        base = set * NWAYS;
        v = 0;
        found = 0;
        for (int w = 0; w < NWAYS; w++)
            if (!found && sh_valid[base + w] && sh_tag[base + w] == tg)
            begin
                found = 1;
                v = w;
            end
        r.hit = found;
        if (!found)
        begin
            oldest = 0;
            for (int w = 0; w < NWAYS; w++)
            begin
                if (!sh_valid[base + w])
                begin
                    v = w;
                    break;
                end
                if (w == 0 || sh_rank[base + w] > oldest)
                begin
                    oldest = sh_rank[base + w];
                    v = w;
                end
            end
            // Dirty victim goes back only in write-back mode
            if (sh_valid[base + v] && sh_dirty[base + v] && wb_mode)
            begin
                ev = {sh_tag[base + v], set, 4'h0};
                for (int j = 0; j < NLB; j++)
                    sh_mem[ev + j] = sh_bytes[base + v][j];
                r.wb = 1;
                r.vla = ev[15:4];
            end
            for (int j = 0; j < NLB; j++)
                sh_bytes[base + v][j] = sh_mem[lb + j];
            promote(base, v);
            sh_valid[base + v] = 1;
            sh_dirty[base + v] = wr ? wb_mode : 1'b0;
            sh_tag[base + v] = tg;
        end
        else
            promote(base, v);
        if (wr)
        begin
            sh_bytes[base + v][off] = d;
            if (wb_mode)
                sh_dirty[base + v] = 1;
            else
                for (int j = 0; j < NLB; j++)
                    sh_mem[lb + j] = sh_bytes[base + v][j];
        end
        else
            r.rdata = sh_bytes[base + v][off];
        return r;
    endfunction

    assign pending = expected_words.size();

    initial
    begin
        errors = 0;
        wb_mode = 1;
        for (int i = 0; i < DEF_LINES; i++)
        begin
            sh_valid[i] = 0;
            sh_dirty[i] = 0;
            sh_tag[i] = 0;
            sh_rank[i] = 0;
            for (int j = 0; j < NLB; j++)
                sh_bytes[i][j] = 0;
        end
        for (int i = 0; i < 65536; i++)
            sh_mem[i] = 0;
    end

    // Predict on accepted commands, compare on result words
    always @(posedge clk)
    begin
        cache_result_t e;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    e = expected_words.pop_front();
                    if (hit !== e.hit)
                    begin
                        $error("hit: expected %0h, got %0h", e.hit, hit);
                        errors++;
                    end
                    if (read_data !== e.rdata)
                    begin
                        $error("read_data: expected %0h, got %0h", e.rdata, read_data);
                        errors++;
                    end
                    if (wrote_back !== e.wb)
                    begin
                        $error("wrote_back: expected %0h, got %0h", e.wb, wrote_back);
                        errors++;
                    end
                    if (victim_line_address !== e.vla)
                    begin
                        $error("victim_line_address: expected %0h, got %0h",
                               e.vla, victim_line_address);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                expected_words.push_back(access_cache(command, address, write_data));
            if (cfg_write_en)
                wb_mode = cfg_write_data;
        end
    end
endmodule

/* bench/testbench.sv */
// Top of the cache regression: clock, reset, command stimulus and verdict.
// Depends on salc_pkg, cache_checker and set_assoc_lru_cache_core.
module testbench import salc_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint CYCLE_LIMIT = 2_000_000;

    logic                   clk = 0;
    logic                   rst_n = 0;
    logic                   cfg_write_en = 0;
    logic                   cfg_write_data = 0;
    logic                   start = 0;
    logic                   command = CMD_READ;
    logic [ADDR_PORT_W-1:0] address = '0;
    logic [BYTE_W-1:0]      write_data = '0;
    logic                   busy;
    logic                   done;
    logic                   hit;
    logic [BYTE_W-1:0]      read_data;
    logic                   wrote_back;
    logic [VLA_W-1:0]       victim_line_address;
    int                     errors;
    int                     pending;
    longint                 cycles = 0;

    always #6 clk = ~clk;

    set_assoc_lru_cache_core uut (.*);

    cache_checker chk (.*);

    // Run-away guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("set_assoc_lru_cache_core regression: fail");
            $finish;
        end
    end

    // Issue one access word and wait for its acceptance; start is left high
    // while the block is busy, and dropped before any idle gap
    task automatic issue(logic wr, logic [15:0] a, logic [7:0] d);
        int gap;
        gap = $urandom_range(0, 9);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            start <= 0;
            repeat (gap) @(negedge clk);
        end
        start <= 1;
        command <= wr;
        address <= a;
        write_data <= d;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Drain all results, then let the block go quiet
    task automatic settle();
        start <= 0;
        while (pending != 0)
            @(negedge clk);
        while (busy)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_mode(logic m);
        settle();
        cfg_write_en <= 1;
        cfg_write_data <= m;
        @(negedge clk);
        cfg_write_en <= 0;
    endtask

    // Random access, mostly clustered on a few sets and tags to force eviction
    task automatic random_access();
        logic [15:0] a;
        a = 16'($urandom);
        if ($urandom_range(0, 3) != 0)
            a = {5'b0, 3'($urandom_range(0, 7)), 4'($urandom_range(0, 1)), a[3:0]};
        if ($urandom_range(0, 9) == 0)
            a[15:13] = 3'($urandom);
        issue(1'($urandom_range(0, 1)), a, 8'($urandom));
    endtask

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1;

        // Directed: extremes, hits, misses, eviction of dirty line from one set
        issue(CMD_READ, 16'h0000, 8'h00);
        issue(CMD_WRITE, 16'hFFFF, 8'hFF);
        issue(CMD_READ, 16'hFFFF, 8'h00);
        issue(CMD_WRITE, 16'h0000, 8'hA5);
        for (int t = 1; t <= 5; t++)
            issue(CMD_WRITE, {8'(t), 8'h00}, 8'(t * 17));
        issue(CMD_READ, 16'h0000, 8'h00);
        issue(CMD_READ, 16'h0100, 8'h00);

        // Write-through, including hits on lines left dirty
        set_mode(0);
        issue(CMD_WRITE, 16'h0502, 8'h5A);
        for (int t = 6; t <= 10; t++)
            issue(CMD_WRITE, {8'(t), 8'h00}, 8'(t));
        issue(CMD_READ, 16'h0502, 8'h00);
        issue(CMD_READ, 16'hFFF0, 8'h00);

        // Random phases, alternating modes
        for (int ph = 0; ph < 6; ph++)
        begin
            set_mode(ph[0]);
            for (int i = 0; i < 100; i++)
                random_access();
        end

        settle();
        if (errors == 0)
            $display("set_assoc_lru_cache_core regression: pass");
        else
            $display("set_assoc_lru_cache_core regression: fail");
        $finish;
    end
endmodule
